FILE: rtl/oxygen_analyzer_calibrate_measure_defines.svh
// assertion macros for the oxygen analyzer checker
// expects clk and rst in the scope where a macro is used
`ifndef OXYGEN_ANALYZER_CALIBRATE_MEASURE_DEFINES_SVH
`define OXYGEN_ANALYZER_CALIBRATE_MEASURE_DEFINES_SVH

// same-cycle implication
`define OAC_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("oac check failed");

// next-cycle implication
`define OAC_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("oac check failed");

`endif

FILE: rtl/oac_pkg.sv
// shared types, constants and helpers of the oxygen analyzer
// no dependencies
package oac_pkg;

  localparam int MaxSamples = 255;
  localparam int DivNW = 56;
  localparam int DivDW = 45;
  localparam int DivCntW = $clog2(DivNW);

  localparam logic [1:0] CalOk      = 2'd0;
  localparam logic [1:0] CalWarnLow = 2'd1;
  localparam logic [1:0] CalErrLow  = 2'd2;
  localparam logic [1:0] CalErrHigh = 2'd3;

  localparam logic KindCal  = 1'b0;
  localparam logic KindMeas = 1'b1;

  localparam logic [2:0] RegDebounce  = 3'd0;
  localparam logic [2:0] RegLongPress = 3'd1;
  localparam logic [2:0] RegCalHigh   = 3'd2;
  localparam logic [2:0] RegCalError  = 3'd3;
  localparam logic [2:0] RegCalWarn   = 3'd4;
  localparam logic [2:0] RegCalSamp   = 3'd5;
  localparam logic [2:0] RegMeasSamp  = 3'd6;
  localparam logic [2:0] RegAirOxygen = 3'd7;

  localparam logic [13:0] OxyFull    = 14'd10000;
  localparam logic [13:0] PpoLow     = 14'd14000;
  localparam logic [13:0] PpoHigh    = 14'd16000;
  localparam logic [10:0] ScaleSalt  = 11'd1000;
  localparam logic [10:0] ScaleFresh = 11'd1030;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] long_press_ticks;
    logic [14:0] cal_high_limit;
    logic [14:0] cal_error_limit;
    logic [14:0] cal_warn_limit;
    logic [7:0]  cal_samples;
    logic [7:0]  meas_samples;
    logic [13:0] air_oxygen;
  } cfg_t;

  typedef enum logic [2:0] {
    RUN_CAL  = 3'b001,
    RUN_MEAS = 3'b010,
    RUN_HALT = 3'b100
  } run_phase_t;

  typedef enum logic [3:0] {
    BTN_RELEASED = 4'b0001,
    BTN_DEBOUNCE = 4'b0010,
    BTN_PRESSED  = 4'b0100,
    BTN_LONG     = 4'b1000
  } btn_phase_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACC,
    OP_MEAN_GO,
    OP_MEAN_TAKE,
    OP_CLASS,
    OP_MUL1,
    OP_MUL2,
    OP_CMP,
    OP_OXY_TAKE,
    OP_DMUL1,
    OP_DSUB,
    OP_DMUL2,
    OP_DDIV_GO,
    OP_DDIV_TAKE,
    OP_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   meas;
    logic   high_pass;
  } dp_cmd_t;

  typedef struct packed {
    logic run_done;
    logic div_done;
    logic zero_path;
    logic clamp;
    logic class_reliable;
  } dp_stat_t;

  function automatic logic [7:0] run_length(input logic [7:0] cfg_len);
    logic [7:0] len;
    if (cfg_len == '0) begin
      len = 8'd1;
    end else if (32'(cfg_len) > MaxSamples) begin
      len = 8'(MaxSamples);
    end else begin
      len = cfg_len;
    end
    return len;
  endfunction

endpackage

FILE: rtl/oxygen_analyzer_calibrate_measure.sv
// top level of the oxygen analyzer: configuration registers and module wiring
// depends on oac_pkg, oac_button, oac_ctrl, oac_dp
//
// usage: the item channel (item_valid/item_stall) carries either a one
// millisecond tick with the button level (command 0) or a signed adc code
// (command 1). a transaction is taken when item_valid is high and item_stall
// is low. the sample that ends a run starts the run-end sequence, during
// which item_stall stays high. calibrations divide for the mean; measurements
// also divide for the oxygen ratio unless it clamps and for both depths, if
// the sum is positive and the air oxygen setting is not zero. all use the
// shared divider, which retires one quotient bit per cycle over 56 bits.
// results leave on result_valid/result_stall from an output register; new
// transactions are still taken while a result waits, and a further run end
// holds in its last step until the pending result is taken. configuration
// must be written through cfg_write/cfg_index/cfg_data only while idle; the
// block itself does not enforce this. reset (rst, synchronous) restores
// register defaults, idles the button, clears sums and starts a calibration
// run; no result is pending after it.
module oxygen_analyzer_calibrate_measure import oac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        command,
  input  logic        button_down,
  input  logic [15:0] sample_code,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        result_kind,
  output logic [1:0]  cal_status,
  output logic        sensor_reliable,
  output logic [15:0] mean_code,
  output logic [13:0] oxygen_level,
  output logic [15:0] depth_limit_low,
  output logic [15:0] depth_limit_high,
  output logic        depth_saturated,
  output logic        fresh_water
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     tick;
  logic     trigger;
  logic     water_select;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= 16'd50;
      cfg.long_press_ticks <= 16'd3000;
      cfg.cal_high_limit   <= 15'd2560;
      cfg.cal_error_limit  <= 15'd640;
      cfg.cal_warn_limit   <= 15'd960;
      cfg.cal_samples      <= 8'd100;
      cfg.meas_samples     <= 8'd33;
      cfg.air_oxygen       <= 14'd2090;
    end else if (cfg_write) begin
      unique case (cfg_index)
        RegDebounce:  cfg.debounce_ticks   <= cfg_data;
        RegLongPress: cfg.long_press_ticks <= cfg_data;
        RegCalHigh:   cfg.cal_high_limit   <= cfg_data[14:0];
        RegCalError:  cfg.cal_error_limit  <= cfg_data[14:0];
        RegCalWarn:   cfg.cal_warn_limit   <= cfg_data[14:0];
        RegCalSamp:   cfg.cal_samples      <= cfg_data[7:0];
        RegMeasSamp:  cfg.meas_samples     <= cfg_data[7:0];
        RegAirOxygen: cfg.air_oxygen       <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  assign tick = item_valid && !item_stall && !command;

  oac_button u_button (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .tick         (tick),
    .pressed      (button_down),
    .water_select (water_select),
    .trigger      (trigger)
  );

  oac_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .command      (command),
    .trigger      (trigger),
    .result_stall (result_stall),
    .stat         (stat),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .cmd          (cmd)
  );

  oac_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd              (cmd),
    .sample_code      (sample_code),
    .water_select     (water_select),
    .stat             (stat),
    .result_kind      (result_kind),
    .cal_status       (cal_status),
    .sensor_reliable  (sensor_reliable),
    .mean_code        (mean_code),
    .oxygen_level     (oxygen_level),
    .depth_limit_low  (depth_limit_low),
    .depth_limit_high (depth_limit_high),
    .depth_saturated  (depth_saturated),
    .fresh_water      (fresh_water)
  );

endmodule

FILE: rtl/oac_div.sv
// restoring divider, one quotient bit per cycle
// depends on oac_pkg
module oac_div import oac_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DivNW-1:0]   dividend,
  input  logic [DivDW-1:0]   divisor,
  output logic               done,
  output logic [DivNW-1:0]   quotient
);

  logic               busy;
  logic [DivCntW-1:0] count;
  logic [DivNW-1:0]   acc;
  logic [DivDW-1:0]   rem;
  logic [DivDW-1:0]   dvs;
  logic [DivDW:0]     rem_sh;
  logic               fits;

  assign rem_sh   = {rem, acc[DivNW-1]};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == DivCntW'(DivNW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= dividend;
      rem   <= '0;
      dvs   <= divisor;
      count <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= DivDW'(rem_sh - {1'b0, dvs});
      end else begin
        rem <= rem_sh[DivDW-1:0];
      end
      acc   <= {acc[DivNW-2:0], fits};
      count <= count + 1'b1;
    end
  end

endmodule

FILE: rtl/oac_button.sv
// button debouncer: short press toggles water scale, long press triggers recalibration
// depends on oac_pkg
module oac_button import oac_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic tick,
  input  logic pressed,
  output logic water_select,
  output logic trigger
);

  btn_phase_t  phase, phase_next;
  logic [15:0] timer, timer_next;
  logic [15:0] timer_inc;
  logic        water_next;

  assign timer_inc = (timer == 16'hFFFF) ? timer : timer + 16'd1;

  always_comb begin
    phase_next = phase;
    timer_next = timer;
    water_next = water_select;
    trigger    = 1'b0;
    if (tick) begin
      unique case (phase)
        BTN_RELEASED: begin
          if (pressed) begin
            phase_next = BTN_DEBOUNCE;
            timer_next = '0;
          end
        end
        BTN_DEBOUNCE: begin
          if (!pressed) begin
            phase_next = BTN_RELEASED;
          end else if (timer_inc > cfg.debounce_ticks) begin
            phase_next = BTN_PRESSED;
            timer_next = '0;
          end else begin
            timer_next = timer_inc;
          end
        end
        BTN_PRESSED: begin
          if (!pressed) begin
            water_next = ~water_select;
            phase_next = BTN_RELEASED;
          end else begin
            timer_next = timer_inc;
            if (timer_inc > cfg.long_press_ticks) begin
              trigger    = 1'b1;
              phase_next = BTN_LONG;
            end
          end
        end
        BTN_LONG: begin
          if (!pressed) begin
            phase_next = BTN_RELEASED;
          end
        end
        default: phase_next = BTN_RELEASED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= BTN_RELEASED;
      timer        <= '0;
      water_select <= 1'b0;
    end else begin
      phase        <= phase_next;
      timer        <= timer_next;
      water_select <= water_next;
    end
  end

endmodule

FILE: rtl/oac_dp.sv
// datapath: run accumulation, classification, oxygen and depth arithmetic, result register
// depends on oac_pkg and oac_div
module oac_dp import oac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  dp_cmd_t     cmd,
  input  logic [15:0] sample_code,
  input  logic        water_select,
  output dp_stat_t    stat,
  output logic        result_kind,
  output logic [1:0]  cal_status,
  output logic        sensor_reliable,
  output logic [15:0] mean_code,
  output logic [13:0] oxygen_level,
  output logic [15:0] depth_limit_low,
  output logic [15:0] depth_limit_high,
  output logic        depth_saturated,
  output logic        fresh_water
);

  logic [23:0] sum;
  logic [7:0]  cnt;
  logic [23:0] s_run;
  logic [7:0]  n_run;
  logic        run_meas;
  logic [23:0] cal_sum;
  logic [7:0]  cal_len;
  logic [1:0]  last_status;
  logic        reliable;

  logic [15:0] mean;
  logic [30:0] p1;
  logic [30:0] d;
  logic [44:0] num;
  logic [44:0] t;
  logic [13:0] oxy;
  logic [44:0] pd;
  logic [44:0] diff;
  logic [55:0] prod;
  logic [15:0] depth_lo;
  logic [15:0] depth_hi;
  logic        dsat;

  logic [23:0] sum_next;
  logic [7:0]  cnt_inc;
  logic [7:0]  n_cfg;
  logic [23:0] s_abs;
  logic [22:0] c_pos;
  logic [22:0] hi_n;
  logic [22:0] err_n;
  logic [22:0] warn_n;
  logic        gt_high;
  logic        lt_err;
  logic        lt_warn;
  logic [1:0]  status_new;

  logic             div_start;
  logic [DivNW-1:0] div_dvd;
  logic [DivDW-1:0] div_dvs;
  logic             div_done;
  logic [DivNW-1:0] div_q;
  logic             q_over;
  logic [15:0]      depth_val;
  logic             zero_path;

  oac_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  assign sum_next = sum + {{8{sample_code[15]}}, sample_code};
  assign cnt_inc  = cnt + 8'd1;
  assign n_cfg    = run_length(cmd.meas ? cfg.meas_samples : cfg.cal_samples);
  assign s_abs    = s_run[23] ? 24'(-s_run) : s_run;
  assign c_pos    = ($signed(cal_sum) > 0) ? cal_sum[22:0] : '0;

  assign hi_n   = 23'(cfg.cal_high_limit) * 23'(n_run);
  assign err_n  = 23'(cfg.cal_error_limit) * 23'(n_run);
  assign warn_n = 23'(cfg.cal_warn_limit) * 23'(n_run);
  assign gt_high = $signed(s_run) > $signed({1'b0, hi_n});
  assign lt_err  = $signed(s_run) < $signed({1'b0, err_n});
  assign lt_warn = $signed(s_run) < $signed({1'b0, warn_n});

  always_comb begin
    if (gt_high) begin
      status_new = CalErrHigh;
    end else if (lt_err) begin
      status_new = CalErrLow;
    end else if (lt_warn) begin
      status_new = CalWarnLow;
    end else begin
      status_new = CalOk;
    end
  end

  assign zero_path = ($signed(s_run) <= 0) || (cfg.air_oxygen == '0);
  assign q_over    = |div_q[DivNW-1:16];
  assign depth_val = q_over ? 16'hFFFF : div_q[15:0];

  assign stat.run_done       = cnt_inc >= n_cfg;
  assign stat.div_done       = div_done;
  assign stat.zero_path      = zero_path;
  assign stat.clamp          = (d == '0) || (num >= t);
  assign stat.class_reliable = !gt_high && !lt_err;

  always_comb begin
    div_start = 1'b0;
    div_dvd   = DivNW'(prod);
    div_dvs   = num;
    case (cmd.op)
      OP_MEAN_GO: begin
        div_start = 1'b1;
        div_dvd   = DivNW'(s_abs);
        div_dvs   = DivDW'(n_run);
      end
      OP_CMP: begin
        div_start = !stat.clamp;
        div_dvd   = DivNW'(num);
        div_dvs   = DivDW'(d);
      end
      OP_DDIV_GO: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum         <= '0;
      cnt         <= '0;
      cal_sum     <= '0;
      cal_len     <= 8'd1;
      last_status <= CalOk;
      reliable    <= 1'b0;
    end else begin
      case (cmd.op)
        OP_CLEAR: begin
          sum <= '0;
          cnt <= '0;
        end
        OP_ACC: begin
          if (stat.run_done) begin
            sum <= '0;
            cnt <= '0;
          end else begin
            sum <= sum_next;
            cnt <= cnt_inc;
          end
        end
        OP_CLASS: begin
          last_status <= status_new;
          reliable    <= stat.class_reliable;
          cal_sum     <= s_run;
          cal_len     <= n_run;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACC: begin
        if (stat.run_done) begin
          s_run    <= sum_next;
          n_run    <= cnt_inc;
          run_meas <= cmd.meas;
        end
      end
      OP_MEAN_TAKE: mean <= s_run[23] ? 16'(-div_q[15:0]) : div_q[15:0];
      OP_MUL1: begin
        p1   <= 31'(s_run[22:0]) * 31'(cal_len);
        d    <= 31'(n_run) * 31'(c_pos);
        dsat <= 1'b0;
      end
      OP_MUL2: begin
        num <= 45'(p1) * 45'(cfg.air_oxygen);
        t   <= 45'(d) * 45'(OxyFull);
      end
      OP_CMP: begin
        if (stat.clamp) begin
          oxy <= OxyFull;
          num <= 45'(OxyFull);
          d   <= 31'd1;
        end
      end
      OP_OXY_TAKE: oxy <= div_q[13:0];
      OP_DMUL1: pd <= 45'(d) * 45'(cmd.high_pass ? PpoHigh : PpoLow);
      OP_DSUB: diff <= pd - num;
      OP_DMUL2: prod <= 56'(diff) * 56'(water_select ? ScaleFresh : ScaleSalt);
      OP_DDIV_TAKE: begin
        dsat <= dsat | q_over;
        if (cmd.high_pass) begin
          depth_hi <= depth_val;
        end else begin
          depth_lo <= depth_val;
        end
      end
      OP_LOAD: begin
        result_kind     <= run_meas;
        cal_status      <= last_status;
        sensor_reliable <= reliable;
        mean_code       <= mean;
        fresh_water     <= water_select;
        if (!run_meas) begin
          oxygen_level     <= '0;
          depth_limit_low  <= '0;
          depth_limit_high <= '0;
          depth_saturated  <= 1'b0;
        end else if (zero_path) begin
          oxygen_level     <= '0;
          depth_limit_low  <= 16'hFFFF;
          depth_limit_high <= 16'hFFFF;
          depth_saturated  <= 1'b1;
        end else begin
          oxygen_level     <= oxy;
          depth_limit_low  <= depth_lo;
          depth_limit_high <= depth_hi;
          depth_saturated  <= dsat;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/oac_ctrl.sv
// controller: input handshake, run phase and run-end sequencing, result valid
// depends on oac_pkg
module oac_ctrl import oac_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  input  logic     command,
  input  logic     trigger,
  input  logic     result_stall,
  input  dp_stat_t stat,
  output logic     item_stall,
  output logic     result_valid,
  output dp_cmd_t  cmd
);

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_MEAN_GO   = 14'b00000000000010,
    S_MEAN_WAIT = 14'b00000000000100,
    S_CLASS     = 14'b00000000001000,
    S_MUL1      = 14'b00000000010000,
    S_MUL2      = 14'b00000000100000,
    S_CMP       = 14'b00000001000000,
    S_OXY_WAIT  = 14'b00000010000000,
    S_DMUL1     = 14'b00000100000000,
    S_DSUB      = 14'b00001000000000,
    S_DMUL2     = 14'b00010000000000,
    S_DDIV_GO   = 14'b00100000000000,
    S_DDIV_WAIT = 14'b01000000000000,
    S_OUT       = 14'b10000000000000
  } state_t;

  state_t     state, state_next;
  run_phase_t run_phase, run_phase_next;
  logic       high_pass, high_pass_next;
  logic       result_valid_next;
  logic       accept;

  assign item_stall = state != S_IDLE;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    state_next        = state;
    run_phase_next    = run_phase;
    high_pass_next    = high_pass;
    result_valid_next = result_valid && result_stall;
    cmd.op            = OP_NONE;
    cmd.meas          = run_phase == RUN_MEAS;
    cmd.high_pass     = high_pass;
    unique case (state)
      S_IDLE: begin
        if (accept && !command && trigger) begin
          cmd.op         = OP_CLEAR;
          run_phase_next = RUN_CAL;
        end else if (accept && command && run_phase != RUN_HALT) begin
          cmd.op = OP_ACC;
          if (stat.run_done) begin
            state_next = S_MEAN_GO;
          end
        end
      end
      S_MEAN_GO: begin
        cmd.op     = OP_MEAN_GO;
        state_next = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (stat.div_done) begin
          cmd.op = OP_MEAN_TAKE;
          if (run_phase == RUN_CAL) begin
            state_next = S_CLASS;
          end else if (stat.zero_path) begin
            state_next = S_OUT;
          end else begin
            state_next = S_MUL1;
          end
        end
      end
      S_CLASS: begin
        cmd.op         = OP_CLASS;
        run_phase_next = stat.class_reliable ? RUN_MEAS : RUN_HALT;
        state_next     = S_OUT;
      end
      S_MUL1: begin
        cmd.op         = OP_MUL1;
        high_pass_next = 1'b0;
        state_next     = S_MUL2;
      end
      S_MUL2: begin
        cmd.op     = OP_MUL2;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.op     = OP_CMP;
        state_next = stat.clamp ? S_DMUL1 : S_OXY_WAIT;
      end
      S_OXY_WAIT: begin
        if (stat.div_done) begin
          cmd.op     = OP_OXY_TAKE;
          state_next = S_DMUL1;
        end
      end
      S_DMUL1: begin
        cmd.op     = OP_DMUL1;
        state_next = S_DSUB;
      end
      S_DSUB: begin
        cmd.op     = OP_DSUB;
        state_next = S_DMUL2;
      end
      S_DMUL2: begin
        cmd.op     = OP_DMUL2;
        state_next = S_DDIV_GO;
      end
      S_DDIV_GO: begin
        cmd.op     = OP_DDIV_GO;
        state_next = S_DDIV_WAIT;
      end
      S_DDIV_WAIT: begin
        if (stat.div_done) begin
          cmd.op = OP_DDIV_TAKE;
          if (high_pass) begin
            state_next = S_OUT;
          end else begin
            high_pass_next = 1'b1;
            state_next     = S_DMUL1;
          end
        end
      end
      S_OUT: begin
        if (!result_valid || !result_stall) begin
          cmd.op            = OP_LOAD;
          result_valid_next = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      run_phase    <= RUN_CAL;
      high_pass    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      run_phase    <= run_phase_next;
      high_pass    <= high_pass_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

FILE: rtl/oac_checker.sv
// port-level checks of the oxygen analyzer result channel, bound to the top level
// depends on oac_pkg and the assertion macro header
`include "oxygen_analyzer_calibrate_measure_defines.svh"

module oac_checker import oac_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic        result_kind,
  input logic [1:0]  cal_status,
  input logic        sensor_reliable,
  input logic [15:0] mean_code,
  input logic [13:0] oxygen_level,
  input logic [15:0] depth_limit_low,
  input logic [15:0] depth_limit_high,
  input logic        depth_saturated
);

  `OAC_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(mean_code))
  `OAC_ASSERT_NOW(a_cal_zero, result_valid && result_kind == KindCal, oxygen_level == 14'd0 && depth_limit_low == 16'd0 && depth_limit_high == 16'd0 && !depth_saturated)
  `OAC_ASSERT_NOW(a_meas_reliable, result_valid && result_kind == KindMeas, sensor_reliable && (cal_status == CalOk || cal_status == CalWarnLow))
  `OAC_ASSERT_NOW(a_cal_status, result_valid && result_kind == KindCal, sensor_reliable == (cal_status == CalOk || cal_status == CalWarnLow))

endmodule

bind oxygen_analyzer_calibrate_measure oac_checker u_oac_checker (.*);

FILE: sim/oxygen_analyzer_calibrate_measure_tb.sv
// testbench of the oxygen analyzer: button ticks and adc samples are sent in random bursts,
// and every result is checked field by field against an in-bench model of the analyzer
// depends on oac_pkg and oxygen_analyzer_calibrate_measure
module oxygen_analyzer_calibrate_measure_tb;
  import oac_pkg::*;

  typedef enum logic [1:0] {BT_IDLE, BT_DEBOUNCE, BT_HELD, BT_LONG} button_t;
  typedef enum logic [1:0] {RN_CAL, RN_MEAS, RN_HALT} run_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic        reliable;
    logic [15:0] mean;
    logic [13:0] oxygen;
    logic [15:0] depth_lo;
    logic [15:0] depth_hi;
    logic        sat;
    logic        fresh;
  } analysis_t;

  typedef struct {
    logic        cmd;
    logic        btn;
    logic [15:0] code;
    logic        typed;
    logic [1:0]  typed_status;
  } stim_row_t;

  logic        clk, rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        item_valid, item_stall;
  logic        command, button_down;
  logic [15:0] sample_code;
  logic        result_valid, result_stall;
  logic        result_kind;
  logic [1:0]  cal_status;
  logic        sensor_reliable;
  logic [15:0] mean_code;
  logic [13:0] oxygen_level;
  logic [15:0] depth_limit_low, depth_limit_high;
  logic        depth_saturated, fresh_water;

  oxygen_analyzer_calibrate_measure dut (.*);

  // model state
  int unsigned cfg_reg [8];
  button_t     btn_st;
  int unsigned btn_cnt;
  logic        fresh;
  run_t        run_st;
  int          smp_cnt, acc, cal_acc, cal_n;
  logic        reliable;
  logic [1:0]  status;

  analysis_t   pending_results [$];
  int          mismatches;
  int          burst_left;
  int          base_code;
  stim_row_t   directed [$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned eff_len(int unsigned cfg);
    if (cfg == 0) return 1;
    if (cfg > MaxSamples) return MaxSamples;
    return cfg;
  endfunction

  function automatic void model_reset();
    cfg_reg = '{50, 3000, 2560, 640, 960, 100, 33, 2090};
    btn_st = BT_IDLE;
    btn_cnt = 0;
    fresh = 1'b0;
    run_st = RN_CAL;
    smp_cnt = 0;
    acc = 0;
    cal_acc = 0;
    reliable = 1'b0;
    cal_n = 1;
    status = CalOk;
  endfunction

  function automatic void model_tick(logic pressed);
    case (btn_st)
      BT_IDLE: if (pressed) begin
        btn_st = BT_DEBOUNCE;
        btn_cnt = 0;
      end
      BT_DEBOUNCE: begin
        if (!pressed) btn_st = BT_IDLE;
        else begin
          if (btn_cnt < 65535) btn_cnt++;
          if (btn_cnt > cfg_reg[RegDebounce]) begin
            btn_st = BT_HELD;
            btn_cnt = 0;
          end
        end
      end
      BT_HELD: begin
        if (!pressed) begin
          fresh = ~fresh;
          btn_st = BT_IDLE;
        end else begin
          if (btn_cnt < 65535) btn_cnt++;
          if (btn_cnt > cfg_reg[RegLongPress]) begin
            run_st = RN_CAL;
            smp_cnt = 0;
            acc = 0;
            btn_st = BT_LONG;
          end
        end
      end
      default: if (!pressed) btn_st = BT_IDLE;
    endcase
  endfunction

  function automatic longint unsigned depth_of(longint unsigned ppo, longint unsigned d,
                                               longint unsigned num, ref logic sat);
    longint unsigned scale, v;
    scale = fresh ? 1030 : 1000;
    v = scale * (ppo * d - num) / num;
    if (v > 65535) begin
      sat = 1'b1;
      v = 65535;
    end
    return v;
  endfunction

  // returns 1 when the sample ends a run
  function automatic bit model_sample(logic [15:0] code, output analysis_t res);
    int n;
    longint unsigned num, d, oxy;
    logic sat;
    res = '0;
    if (run_st == RN_HALT) return 0;
    acc += int'($signed(code));
    smp_cnt++;
    n = eff_len(run_st == RN_CAL ? cfg_reg[RegCalSamp] : cfg_reg[RegMeasSamp]);
    if (smp_cnt < n) return 0;
    n = smp_cnt;
    res.mean = 16'(acc / n);
    res.fresh = fresh;
    if (run_st == RN_CAL) begin
      if (acc > int'(cfg_reg[RegCalHigh]) * n) begin
        status = CalErrHigh;
        reliable = 1'b0;
      end else if (acc < int'(cfg_reg[RegCalError]) * n) begin
        status = CalErrLow;
        reliable = 1'b0;
      end else if (acc < int'(cfg_reg[RegCalWarn]) * n) begin
        status = CalWarnLow;
        reliable = 1'b1;
      end else begin
        status = CalOk;
        reliable = 1'b1;
      end
      cal_acc = acc;
      cal_n = n;
      res.kind = KindCal;
      run_st = reliable ? RN_MEAS : RN_HALT;
    end else begin
      res.kind = KindMeas;
      if (acc <= 0 || cfg_reg[RegAirOxygen] == 0) begin
        res.depth_lo = 16'hffff;
        res.depth_hi = 16'hffff;
        res.sat = 1'b1;
      end else begin
        sat = 1'b0;
        num = longint'(acc) * cal_n * cfg_reg[RegAirOxygen];
        d = longint'(n) * (cal_acc > 0 ? longint'(cal_acc) : 0);
        if (d == 0 || num >= 10000 * d) begin
          num = 10000;
          d = 1;
          oxy = 10000;
        end else oxy = num / d;
        res.oxygen = 14'(oxy);
        res.depth_lo = 16'(depth_of(14000, d, num, sat));
        res.depth_hi = 16'(depth_of(16000, d, num, sat));
        res.sat = sat;
      end
    end
    res.status = status;
    res.reliable = reliable;
    smp_cnt = 0;
    acc = 0;
    return 1;
  endfunction

  // result side: stall pattern and checking
  int stall_mode, stall_left;
  always @(posedge clk) begin
    analysis_t got, want;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 400);
    end else stall_left <= stall_left - 1;
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 1) == 1);
      2: result_stall <= ($urandom_range(0, 9) != 0);
      default: result_stall <= (stall_left % 64) < 40;
    endcase
    if (!rst && result_valid && !result_stall) begin
      got = '{result_kind, cal_status, sensor_reliable, mean_code, oxygen_level,
              depth_limit_low, depth_limit_high, depth_saturated, fresh_water};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic send_item(logic cmd, logic btn, logic [15:0] code, logic typed = 1'b0,
                           logic [1:0] typed_status = CalOk);
    analysis_t res;
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 20);
    end
    burst_left--;
    item_valid <= 1'b1;
    command <= cmd;
    button_down <= btn;
    sample_code <= code;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (!cmd) model_tick(btn);
    else if (model_sample(code, res)) begin
      if (typed) res.status = typed_status;
      pending_results.push_back(res);
    end
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    logic [15:0] mask [8];
    mask = '{16'hffff, 16'hffff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h00ff, 16'h00ff, 16'h3fff};
    item_valid <= 1'b0;
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_reg[idx] = value & mask[idx];
  endtask

  task automatic long_press();
    int unsigned held;
    held = cfg_reg[RegDebounce] + cfg_reg[RegLongPress] + 3;
    if (held > 20) held = 20;
    repeat (held) send_item(1'b0, 1'b1, '0);
    send_item(1'b0, 1'b0, '0);
  endtask

  task automatic short_press();
    int unsigned held;
    held = cfg_reg[RegDebounce] + 2;
    if (held > 20) held = 20;
    repeat (held) send_item(1'b0, 1'b1, '0);
    send_item(1'b0, 1'b0, '0);
  endtask

  function automatic logic [15:0] pick_code();
    if ($urandom_range(0, 9) < 8) return 16'(base_code + $urandom_range(0, 400) - 200);
    return 16'($urandom);
  endfunction

  initial begin
    int dbn, lng, err;
    model_reset();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_valid = 1'b0;
    command = 1'b0;
    button_down = 1'b0;
    sample_code = '0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    // directed part: single-sample runs, zero debounce and a long-press limit of 1
    write_reg(RegCalSamp, 16'd1);
    write_reg(RegMeasSamp, 16'd1);
    write_reg(RegDebounce, 16'd0);
    write_reg(RegLongPress, 16'd1);
    directed.push_back('{1'b1, 1'b0, 16'h7fff, 1'b1, CalErrHigh});
    directed.push_back('{1'b1, 1'b0, 16'h8000, 1'b0, CalOk});   // halted, ignored
    repeat (4) directed.push_back('{1'b0, 1'b1, 16'h0, 1'b0, CalOk});
    directed.push_back('{1'b0, 1'b0, 16'h0, 1'b0, CalOk});
    directed.push_back('{1'b1, 1'b0, 16'h8000, 1'b1, CalErrLow});
    repeat (4) directed.push_back('{1'b0, 1'b1, 16'h0, 1'b0, CalOk});
    directed.push_back('{1'b0, 1'b0, 16'h0, 1'b0, CalOk});
    directed.push_back('{1'b1, 1'b0, 16'd700, 1'b1, CalWarnLow});
    directed.push_back('{1'b1, 1'b0, 16'd700, 1'b0, CalOk});
    directed.push_back('{1'b1, 1'b0, 16'd0, 1'b0, CalOk});
    directed.push_back('{1'b1, 1'b0, 16'hfffb, 1'b0, CalOk});
    directed.push_back('{1'b1, 1'b0, 16'h7fff, 1'b0, CalOk});
    directed.push_back('{1'b0, 1'b1, 16'h0, 1'b0, CalOk});
    directed.push_back('{1'b0, 1'b1, 16'h0, 1'b0, CalOk});
    directed.push_back('{1'b0, 1'b0, 16'h0, 1'b0, CalOk});
    directed.push_back('{1'b1, 1'b0, 16'd500, 1'b0, CalOk});
    foreach (directed[i])
      send_item(directed[i].cmd, directed[i].btn, directed[i].code,
                directed[i].typed, directed[i].typed_status);
    wait_drained();

    // random part: several register settings, extremes first and last
    for (int p = 0; p < 6; p++) begin
      if (p == 0) begin
        write_reg(RegDebounce, 16'd0);
        write_reg(RegLongPress, 16'd0);
        write_reg(RegCalHigh, 16'h7fff);
        write_reg(RegCalError, 16'd0);
        write_reg(RegCalWarn, 16'd0);
        write_reg(RegCalSamp, 16'd0);
        write_reg(RegMeasSamp, 16'd0);
        write_reg(RegAirOxygen, 16'd10000);
      end else if (p == 5) begin
        long_press();
        write_reg(RegCalSamp, 16'd255);
        write_reg(RegMeasSamp, 16'd255);
        write_reg(RegAirOxygen, 16'd1);
        write_reg(RegCalHigh, 16'h7fff);
        write_reg(RegCalError, 16'd0);
        write_reg(RegCalWarn, 16'h7fff);
        wait_drained();
        long_press();
        wait_drained();
        write_reg(RegDebounce, 16'hffff);
        write_reg(RegLongPress, 16'hffff);
      end else begin
        dbn = $urandom_range(0, 4);
        lng = $urandom_range(0, 8);
        err = $urandom_range(0, 400);
        write_reg(RegDebounce, 16'(dbn));
        write_reg(RegLongPress, 16'(lng));
        write_reg(RegCalError, 16'(err));
        write_reg(RegCalWarn, 16'(err + $urandom_range(0, 600)));
        write_reg(RegCalHigh, ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 1500))
                                                          : 16'($urandom_range(1500, 32767)));
        write_reg(RegCalSamp, 16'($urandom_range(0, 8)));
        write_reg(RegMeasSamp, 16'($urandom_range(0, 6)));
        write_reg(RegAirOxygen, (p == 3) ? 16'(16384 + $urandom_range(0, 16383))
                                         : 16'($urandom_range(1, 10000)));
      end
      base_code = $urandom_range(300, 3000);
      if (p != 5) long_press();
      for (int k = 0; k < 60; k++) begin
        case ($urandom_range(0, 19))
          0: long_press();
          1: short_press();
          2, 3, 4, 5: send_item(1'b0, 1'($urandom), 16'($urandom));
          default: send_item(1'b1, 1'($urandom), pick_code());
        endcase
      end
      wait_drained();
    end

    wait_drained();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
